[hw/rtl/mtts_pkg.sv]
// Shared types and constants for the move-to-target stepper.
// Used by mtts_divsqrt and move_to_target_stepper; depends on nothing.
`default_nettype none

package mtts_pkg;

	// Request codes carried on req_type.
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2,
		REQ_SETPOS = 2'd3
	} req_e_t;

	// Multiplier pass codes used by the top-level sequencer.
	localparam logic [2:0] MS_STEP  = 3'd0;
	localparam logic [2:0] MS_SQX   = 3'd1;
	localparam logic [2:0] MS_SQY   = 3'd2;
	localparam logic [2:0] MS_SQZ   = 3'd3;
	localparam logic [2:0] MS_STEP2 = 3'd4;
	localparam logic [2:0] MS_ADVX  = 3'd5;
	localparam logic [2:0] MS_ADVY  = 3'd6;
	localparam logic [2:0] MS_ADVZ  = 3'd7;

	localparam int WIDE_W  = 66;  // squared distance and products
	localparam int ROOT_W  = 34;  // distance and divisor width
	localparam int REM_W   = 36;  // shared unit remainder
	localparam int CNT_W   = 7;
	localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd66;
	localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd33;

	// Command to the shared divide / square-root unit.
	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} ds_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/mtts_divsqrt.sv]
// Iterative restoring divider and square-root unit sharing one subtractor.
// Depends on mtts_pkg.
`default_nettype none

module mtts_divsqrt
	import mtts_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ds_cmd_t             cmd,
	input  wire logic [WIDE_W-1:0]   operand,
	input  wire logic [ROOT_W-1:0]   divisor,
	output logic                     busy,
	output logic                     done,
	output logic [WIDE_W-1:0]        result
);

	logic [REM_W-1:0]  rem_q;
	logic [WIDE_W-1:0] q_q;
	logic [WIDE_W-1:0] opnd_q;
	logic [ROOT_W-1:0] dvsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              mode_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0]  pre;
	logic [REM_W-1:0]  sub;
	logic [REM_W:0]    diff;
	logic              ge;

	// One digit per cycle: a radix-4 pair for the root, one bit for division.
	always_comb begin
		if (mode_q) begin
			pre = {rem_q[REM_W-3:0], opnd_q[WIDE_W-1 -: 2]};
			sub = {q_q[ROOT_W-1:0], 2'b01};
		end else begin
			pre = {rem_q[REM_W-2:0], opnd_q[WIDE_W-1]};
			sub = {2'b00, dvsr_q};
		end
		diff = {1'b0, pre} - {1'b0, sub};
		ge   = ~diff[REM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				mode_q <= cmd.sqrt_mode;
				cnt_q  <= cmd.sqrt_mode ? SQRT_STEPS : DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= '0;
			q_q    <= '0;
			opnd_q <= operand;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[REM_W-1:0] : pre;
			q_q    <= {q_q[WIDE_W-2:0], ge};
			opnd_q <= mode_q ? {opnd_q[WIDE_W-3:0], 2'b00} : {opnd_q[WIDE_W-2:0], 1'b0};
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = q_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q) else $error("unit did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while still iterating");

endmodule

`default_nettype wire

[hw/rtl/move_to_target_stepper.sv]
// Top level of the move-to-target stepper: request sequencer, shared multiplier
// and output register. Depends on mtts_pkg and mtts_divsqrt.
`default_nettype none

// Channel  Direction  Handshake           Beat contents
// in       input      in_valid/in_stall   req_type, coord_x/y/z, speed_in, elapsed_time
// out      output     out_valid/out_stall pos_x/y/z, is_moving, arrived, travel_time
//
// Stop, set position and a tick while not moving go straight to the output state.
// A start move runs the 33-step square root and then the 66-step division in the
// shared divide / square-root unit.
// A tick that advances runs the root, then one 66-step division per axis.
// Reset clears position, target, speed and the moving flag to zero.
// in_stall is high while a beat is in work; a finished result waits in the
// output register, and a stalled output holds the sequencer at its last state.

module move_to_target_stepper
	import mtts_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	input  wire logic [23:0]        speed_in,
	input  wire logic [23:0]        elapsed_time,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic                    is_moving,
	output logic                    arrived,
	output logic [31:0]             travel_time
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_ACC,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t             state_q;
	req_e_t             req_q;
	logic [2:0]         sel_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] tgt_q [3];
	logic [23:0]        speed_q;
	logic               moving_q;
	logic [23:0]        elapsed_q;
	logic [32:0]        dmag_q [3];
	logic               dneg_q [3];
	logic [WIDE_W-1:0]  sum_q;
	logic [WIDE_W-1:0]  prod_q;
	logic [31:0]        step_q;
	logic [ROOT_W-1:0]  dist_q;
	logic               arrived_q;
	logic [31:0]        travel_q;

	// Output register.
	logic               out_valid_q;
	logic signed [31:0] opos_q [3];
	logic               omoving_q;
	logic               oarrived_q;
	logic [31:0]        otravel_q;

	// Shared divide / square-root unit interface.
	ds_cmd_t            ds_cmd_q;
	logic [WIDE_W-1:0]  ds_opnd_q;
	logic [ROOT_W-1:0]  ds_dvsr_q;
	logic               ds_busy;
	logic               ds_done;
	logic [WIDE_W-1:0]  ds_result;

	logic [32:0]        mul_a;
	logic [32:0]        mul_b;
	logic [32:0]        sdiff [3];
	logic [32:0]        adv;
	logic [1:0]         axis;

	mtts_divsqrt u_divsqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ds_cmd_q),
		.operand (ds_opnd_q),
		.divisor (ds_dvsr_q),
		.busy    (ds_busy),
		.done    (ds_done),
		.result  (ds_result)
	);

	// Signed offsets toward the target, one 33-bit subtract per axis.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sdiff[i] = {tgt_q[i][31], tgt_q[i]} - {pos_q[i][31], pos_q[i]};
		end
	end

	// Operand selection for the single shared multiplier.
	always_comb begin
		case (sel_q)
			MS_STEP: begin
				mul_a = {9'd0, elapsed_q};
				mul_b = {9'd0, speed_q};
			end
			MS_SQX: begin
				mul_a = dmag_q[0];
				mul_b = dmag_q[0];
			end
			MS_SQY: begin
				mul_a = dmag_q[1];
				mul_b = dmag_q[1];
			end
			MS_SQZ: begin
				mul_a = dmag_q[2];
				mul_b = dmag_q[2];
			end
			MS_STEP2: begin
				mul_a = {1'b0, step_q};
				mul_b = {1'b0, step_q};
			end
			MS_ADVX: begin
				mul_a = dmag_q[0];
				mul_b = {1'b0, step_q};
			end
			MS_ADVY: begin
				mul_a = dmag_q[1];
				mul_b = {1'b0, step_q};
			end
			MS_ADVZ: begin
				mul_a = dmag_q[2];
				mul_b = {1'b0, step_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// The axis being advanced follows the advance pass code.
	assign axis = (sel_q == MS_ADVX) ? 2'd0 : (sel_q == MS_ADVY) ? 2'd1 : 2'd2;
	assign adv  = ds_result[32:0];

	// The product register sits after the multiplier, before any use.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= REQ_TICK;
			sel_q       <= MS_STEP;
			moving_q    <= 1'b0;
			speed_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				tgt_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
			ds_cmd_q    <= '0;
		end else begin
			// The start command lasts one cycle; no new command is issued meanwhile.
			if (ds_cmd_q.start) begin
				ds_cmd_q <= '0;
			end
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q     <= req_e_t'(req_type);
						elapsed_q <= elapsed_time;
						arrived_q <= 1'b0;
						travel_q  <= '0;
						case (req_e_t'(req_type))
							REQ_TICK: begin
								sel_q   <= MS_STEP;
								state_q <= moving_q ? ST_DIFF : ST_OUT;
							end
							REQ_START: begin
								tgt_q[0] <= coord_x;
								tgt_q[1] <= coord_y;
								tgt_q[2] <= coord_z;
								speed_q  <= speed_in;
								moving_q <= 1'b1;
								sel_q    <= MS_SQX;
								state_q  <= ST_DIFF;
							end
							REQ_STOP: begin
								moving_q <= 1'b0;
								state_q  <= ST_OUT;
							end
							REQ_SETPOS: begin
								pos_q[0] <= coord_x;
								pos_q[1] <= coord_y;
								pos_q[2] <= coord_z;
								state_q  <= ST_OUT;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						dneg_q[i] <= sdiff[i][32];
						dmag_q[i] <= sdiff[i][32] ? (33'd0 - sdiff[i]) : sdiff[i];
					end
					sum_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					case (sel_q)
						MS_STEP: begin
							step_q  <= prod_q[47:16];
							sel_q   <= MS_SQX;
							state_q <= ST_MUL;
						end
						MS_SQX, MS_SQY: begin
							sum_q   <= sum_q + prod_q;
							sel_q   <= sel_q + 3'd1;
							state_q <= ST_MUL;
						end
						MS_SQZ: begin
							sum_q <= sum_q + prod_q;
							if (req_q == REQ_TICK) begin
								sel_q   <= MS_STEP2;
								state_q <= ST_MUL;
							end else begin
								ds_cmd_q  <= '{start: 1'b1, sqrt_mode: 1'b1};
								ds_opnd_q <= sum_q + prod_q;
								state_q   <= ST_SQRT;
							end
						end
						MS_STEP2: begin
							// The step covers what is left: snap to the target.
							if (prod_q >= sum_q) begin
								pos_q     <= tgt_q;
								moving_q  <= 1'b0;
								arrived_q <= 1'b1;
								state_q   <= ST_OUT;
							end else if (step_q == '0) begin
								state_q <= ST_OUT;
							end else begin
								ds_cmd_q  <= '{start: 1'b1, sqrt_mode: 1'b1};
								ds_opnd_q <= sum_q;
								state_q   <= ST_SQRT;
							end
						end
						default: begin
							ds_cmd_q  <= '{start: 1'b1, sqrt_mode: 1'b0};
							ds_opnd_q <= prod_q;
							ds_dvsr_q <= dist_q;
							state_q   <= ST_DIV;
						end
					endcase
				end
				ST_SQRT: begin
					if (ds_done) begin
						dist_q <= ds_result[ROOT_W-1:0];
						if (req_q == REQ_TICK) begin
							if (ds_result[ROOT_W-1:0] == '0) begin
								state_q <= ST_OUT;
							end else begin
								sel_q   <= MS_ADVX;
								state_q <= ST_MUL;
							end
						end else if (speed_q == '0) begin
							travel_q <= '1;
							state_q  <= ST_OUT;
						end else begin
							ds_cmd_q  <= '{start: 1'b1, sqrt_mode: 1'b0};
							ds_opnd_q <= {16'd0, ds_result[ROOT_W-1:0], 16'd0};
							ds_dvsr_q <= {10'd0, speed_q};
							state_q   <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (ds_done) begin
						if (req_q == REQ_TICK) begin
							pos_q[axis] <= dneg_q[axis] ? (pos_q[axis] - adv[31:0])
							                            : (pos_q[axis] + adv[31:0]);
							if (sel_q == MS_ADVZ) begin
								state_q <= ST_OUT;
							end else begin
								sel_q   <= sel_q + 3'd1;
								state_q <= ST_MUL;
							end
						end else begin
							// Travel time saturates when the quotient passes 32 bits.
							travel_q <= (|ds_result[WIDE_W-1:32]) ? '1 : ds_result[31:0];
							state_q  <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload is loaded when the beat leaves the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			opos_q     <= pos_q;
			omoving_q  <= moving_q;
			oarrived_q <= arrived_q;
			otravel_q  <= travel_q;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign pos_x       = opos_q[0];
	assign pos_y       = opos_q[1];
	assign pos_z       = opos_q[2];
	assign is_moving   = omoving_q;
	assign arrived     = oarrived_q;
	assign travel_time = otravel_q;

	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ds_busy) else $error("shared unit busy while idle");
	a_start_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && req_type == REQ_START) |=> moving_q)
		else $error("start move did not set the moving flag");
	a_arrive_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && oarrived_q) |-> !omoving_q) else $error("arrived while moving");

endmodule

`default_nettype wire
